### rtl/prl_pkg.sv
// types, constants and request codes for the per-client rate limit table
package prl_pkg;

  localparam int NUM_SLOTS  = 8;
  localparam int SLOT_IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam int TIME_W     = 32;
  localparam int ADDR_W     = 32;
  localparam int COUNT_W    = 8;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FAILURES  = CFG_IDX_W'(1);

  localparam logic [TIME_W-1:0]  WINDOW_RESET = TIME_W'(60000);
  localparam logic [COUNT_W-1:0] MAX_RESET    = COUNT_W'(5);
  localparam logic [COUNT_W-1:0] COUNT_SAT    = {COUNT_W{1'b1}};

  localparam logic [1:0] REQ_CHECK   = 2'd0;
  localparam logic [1:0] REQ_FAILURE = 2'd1;
  localparam logic [1:0] REQ_CLEAR   = 2'd2;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [ADDR_W-1:0] client_addr;
    logic [TIME_W-1:0] now_ms;
  } prl_in_t;

  typedef struct packed {
    logic is_limited;
    logic entry_hit;
  } prl_out_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [COUNT_W-1:0] count;
    logic [TIME_W-1:0]  start;
  } prl_slot_t;

endpackage

### rtl/prl_sub.sv
// shared 32-bit subtractor with borrow, used for time and count compares
module prl_sub (
  input  logic [prl_pkg::TIME_W-1:0] a,
  input  logic [prl_pkg::TIME_W-1:0] b,
  output logic [prl_pkg::TIME_W-1:0] diff,
  output logic                       borrow
);
  import prl_pkg::*;

  logic [TIME_W:0] full;

  assign full   = {1'b0, a} - {1'b0, b};
  assign diff   = full[TIME_W-1:0];
  assign borrow = full[TIME_W];

endmodule

### rtl/per_client_rate_limit_table.sv
// per-client fixed-window failure limiter: slot table, scan sequencer and update
// one request at a time: in_ready is high only in idle, so a new request waits until
// the previous result is written, which stalls while a result beat waits for out_ready;
// the slot scan reads the table memory one slot a cycle, then the shared
// subtractor runs three compares
// synchronous active-low reset clears all slot valid marks, restores the window
// and limit registers, and empties the result register; no clearing pass needed
module per_client_rate_limit_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  prl_pkg::prl_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output prl_pkg::prl_out_t             out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [prl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [prl_pkg::CFG_DATA_W-1:0] cfg_data
);
  import prl_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_ELAPSE,
    ST_EXPIRE,
    ST_LIMIT,
    ST_WRITE
  } state_t;

  localparam logic [SLOT_IDX_W-1:0] LAST_IDX = SLOT_IDX_W'(NUM_SLOTS - 1);

  prl_slot_t mem [0:NUM_SLOTS-1];

  state_t                 state_r;
  prl_in_t                req_r;
  logic [SLOT_IDX_W-1:0]  scan_idx_r;
  logic                   rd_vld_r;
  logic [SLOT_IDX_W-1:0]  rd_idx_r;
  prl_slot_t              rd_q_r;
  logic                   hit_r;
  logic [SLOT_IDX_W-1:0]  match_idx_r;
  logic [TIME_W-1:0]      match_start_r;
  logic [COUNT_W-1:0]     match_count_r;
  logic                   free_found_r;
  logic [SLOT_IDX_W-1:0]  free_idx_r;
  logic [SLOT_IDX_W-1:0]  min_idx_r;
  logic [TIME_W-1:0]      min_start_r;
  logic [TIME_W-1:0]      elapsed_r;
  logic                   expired_r;
  logic                   limited_r;
  logic [NUM_SLOTS-1:0]   valid_r;
  logic [TIME_W-1:0]      window_r;
  logic [COUNT_W-1:0]     max_fail_r;
  logic                   out_valid_r;
  prl_out_t               out_data_r;

  logic [TIME_W-1:0]      sub_a;
  logic [TIME_W-1:0]      sub_b;
  logic [TIME_W-1:0]      sub_diff;
  logic                   sub_borrow;

  logic                   out_free;
  logic                   mem_we;
  logic [SLOT_IDX_W-1:0]  mem_wa;
  prl_slot_t              mem_wd;
  logic                   valid_set;
  logic                   valid_clr;
  prl_out_t               result;

  prl_sub u_sub (
    .a      (sub_a),
    .b      (sub_b),
    .diff   (sub_diff),
    .borrow (sub_borrow)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;

  // operand select for the shared subtractor
  always_comb begin
    unique case (state_r)
      ST_ELAPSE: begin
        sub_a = req_r.now_ms;
        sub_b = match_start_r;
      end
      ST_EXPIRE: begin
        sub_a = window_r;
        sub_b = elapsed_r;
      end
      ST_LIMIT: begin
        sub_a = TIME_W'(match_count_r);
        sub_b = TIME_W'(max_fail_r);
      end
      default: begin
        sub_a = rd_q_r.start;
        sub_b = min_start_r;
      end
    endcase
  end

  // slot update decision
  always_comb begin
    mem_we      = 1'b0;
    mem_wa      = match_idx_r;
    mem_wd.addr = req_r.client_addr;
    mem_wd.count = match_count_r;
    mem_wd.start = req_r.now_ms;
    valid_set   = 1'b0;
    valid_clr   = 1'b0;
    result.is_limited = 1'b0;
    result.entry_hit  = 1'b0;
    case (req_r.req_type)
      REQ_CHECK: begin
        result.entry_hit = hit_r;
        if (hit_r) begin
          if (expired_r) begin
            mem_we       = 1'b1;
            mem_wd.count = '0;
          end else begin
            result.is_limited = limited_r;
          end
        end
      end
      REQ_FAILURE: begin
        result.entry_hit = hit_r;
        mem_we = 1'b1;
        if (hit_r) begin
          if (expired_r) begin
            mem_wd.count = COUNT_W'(1);
          end else begin
            mem_wd.start = match_start_r;
            if (match_count_r != COUNT_SAT) begin
              mem_wd.count = match_count_r + COUNT_W'(1);
            end
          end
        end else begin
          mem_wa       = free_found_r ? free_idx_r : min_idx_r;
          mem_wd.count = COUNT_W'(1);
          valid_set    = 1'b1;
        end
      end
      REQ_CLEAR: begin
        result.entry_hit = hit_r;
        valid_clr        = hit_r;
      end
      default: begin
      end
    endcase
    if (state_r != ST_WRITE || !out_free) begin
      mem_we    = 1'b0;
      valid_set = 1'b0;
      valid_clr = 1'b0;
    end
  end

  // slot table memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (state_r == ST_SCAN) begin
      rd_q_r <= mem[scan_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      scan_idx_r   <= '0;
      rd_vld_r     <= 1'b0;
      hit_r        <= 1'b0;
      free_found_r <= 1'b0;
      valid_r      <= '0;
      window_r     <= WINDOW_RESET;
      max_fail_r   <= MAX_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_WINDOW_LENGTH: window_r   <= cfg_data[TIME_W-1:0];
          REG_MAX_FAILURES:  max_fail_r <= cfg_data[COUNT_W-1:0];
          default: begin
          end
        endcase
      end

      if (state_r == ST_WRITE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      rd_vld_r <= (state_r == ST_SCAN);
      rd_idx_r <= scan_idx_r;

      // fold in the slot read back last cycle
      if (rd_vld_r) begin
        if (valid_r[rd_idx_r] && rd_q_r.addr == req_r.client_addr && !hit_r) begin
          hit_r         <= 1'b1;
          match_idx_r   <= rd_idx_r;
          match_start_r <= rd_q_r.start;
          match_count_r <= rd_q_r.count;
        end
        if (!valid_r[rd_idx_r] && !free_found_r) begin
          free_found_r <= 1'b1;
          free_idx_r   <= rd_idx_r;
        end
        if (rd_idx_r == '0 || sub_borrow) begin
          min_idx_r   <= rd_idx_r;
          min_start_r <= rd_q_r.start;
        end
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            req_r        <= in_data;
            scan_idx_r   <= '0;
            hit_r        <= 1'b0;
            free_found_r <= 1'b0;
            state_r      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_idx_r == LAST_IDX) begin
            state_r <= ST_DRAIN;
          end else begin
            scan_idx_r <= scan_idx_r + SLOT_IDX_W'(1);
          end
        end
        ST_DRAIN: begin
          state_r <= ST_ELAPSE;
        end
        ST_ELAPSE: begin
          elapsed_r <= sub_diff;
          state_r   <= ST_EXPIRE;
        end
        ST_EXPIRE: begin
          expired_r <= sub_borrow;
          state_r   <= ST_LIMIT;
        end
        ST_LIMIT: begin
          limited_r <= !sub_borrow;
          state_r   <= ST_WRITE;
        end
        ST_WRITE: begin
          if (out_free) begin
            if (valid_set) begin
              valid_r[mem_wa] <= 1'b1;
            end
            if (valid_clr) begin
              valid_r[match_idx_r] <= 1'b0;
            end
            out_data_r  <= result;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
